@@ hw/rtl/mpcrt_pkg.sv @@
// Package for the modular power block: word width constant, sequencer state type and unit request struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mpcrt_pkg;
	localparam int WORD_BITS = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MUL,
		ST_NEXT,
		ST_DONE
	} state_t;

	// Request from the sequencer to the shared modular unit.
	typedef struct packed {
		logic start;
		logic reduce;
	} unit_ctl_t;
endpackage
`default_nettype wire

@@ hw/rtl/modular_power_by_crt_top.sv @@
// Modular power block, top level: handshakes, square-and-multiply sequencer, output register.
// Depends on mpcrt_pkg and mpcrt_modunit.
//
// Usage: s_axis carries one request per transaction; tdata holds base (low 64 bits),
// exponent and modulus. m_axis returns one result per request; tdata holds power_mod and
// tuser holds modulus_error. A modulus of zero returns 0 with the error flag set.
// The base is first reduced modulo the modulus. Every exponent bit then costs a square
// and, when set, a multiply through the single shared modular unit; a zero modulus
// skips the unit and goes straight to the done state. Requests are processed one at a
// time and s_axis_tready stays low meanwhile. The result waits in an output register
// while the receiver stalls, and a new request is taken only when that register is
// free. Reset empties the block.
`timescale 1ns / 1ps
`default_nettype none
module modular_power_by_crt_top #(
	parameter int WORD_BITS = mpcrt_pkg::WORD_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [191:0] s_axis_tdata,  // base, exponent, modulus
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [63:0]       m_axis_tdata,  // power_mod
	output logic              m_axis_tuser   // modulus_error
);
	localparam int W = WORD_BITS;
	localparam int EW = $clog2(W);

	mpcrt_pkg::state_t state_q, state_d;
	mpcrt_pkg::unit_ctl_t ctl;
	logic [W-1:0] x_q, e_q, m_q, r_q, u_a, u_b, u_m, u_res;
	logic [EW:0] bit_q;
	logic sq_q, u_done, out_valid_q, err_q;
	logic [63:0] out_data_q;
	logic in_acc;

	assign s_axis_tready = (state_q == mpcrt_pkg::ST_IDLE) && !out_valid_q;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// The reduction starts in the accepting cycle, before m_q holds the new modulus.
	assign u_m = (state_q == mpcrt_pkg::ST_IDLE) ? s_axis_tdata[128 +: W] : m_q;

	mpcrt_modunit #(.W(W)) u_unit (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .a(u_a), .b(u_b), .m(u_m),
		.done(u_done), .result(u_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mpcrt_pkg::ST_IDLE:
				if (in_acc)
					state_d = (s_axis_tdata[128 +: W] == '0) ? mpcrt_pkg::ST_DONE
						: mpcrt_pkg::ST_REDUCE;
			mpcrt_pkg::ST_REDUCE: if (u_done) state_d = mpcrt_pkg::ST_NEXT;
			mpcrt_pkg::ST_MUL: if (u_done) state_d = mpcrt_pkg::ST_NEXT;
			mpcrt_pkg::ST_NEXT:
				if (bit_q == (EW+1)'(W)) state_d = mpcrt_pkg::ST_DONE;
				else if (sq_q || e_q[bit_q[EW-1:0]]) state_d = mpcrt_pkg::ST_MUL;
			mpcrt_pkg::ST_DONE: state_d = mpcrt_pkg::ST_IDLE;
			default: state_d = mpcrt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.start = 1'b0;
		ctl.reduce = 1'b0;
		u_a = r_q;
		u_b = x_q;
		case (state_q)
			mpcrt_pkg::ST_IDLE: begin
				ctl.start = in_acc && (s_axis_tdata[128 +: W] != '0);
				ctl.reduce = 1'b1;
				u_b = s_axis_tdata[W-1:0];
			end
			mpcrt_pkg::ST_NEXT: begin
				ctl.start = (bit_q != (EW+1)'(W)) && (sq_q || e_q[bit_q[EW-1:0]]);
				u_a = sq_q ? x_q : r_q;
				u_b = x_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpcrt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mpcrt_pkg::ST_DONE)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Sequence per exponent bit (LSB first): multiply r by x when the bit is set,
	// then square x. sq_q low means the multiply slot for the current bit.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			e_q <= s_axis_tdata[64 +: W];
			m_q <= s_axis_tdata[128 +: W];
			r_q <= (s_axis_tdata[128 +: W] == W'(1)) ? '0 : W'(1);
			err_q <= (s_axis_tdata[128 +: W] == '0);
			bit_q <= '0;
			sq_q <= 1'b0;
		end
		if (state_q == mpcrt_pkg::ST_REDUCE && u_done)
			x_q <= u_res;
		if (state_q == mpcrt_pkg::ST_MUL && u_done) begin
			if (sq_q) begin
				x_q <= u_res;
				bit_q <= bit_q + 1'b1;
				sq_q <= 1'b0;
			end else begin
				r_q <= u_res;
				sq_q <= 1'b1;
			end
		end
		if (state_q == mpcrt_pkg::ST_NEXT && bit_q != (EW+1)'(W) && !sq_q
				&& !e_q[bit_q[EW-1:0]])
			sq_q <= 1'b1;
		if (state_q == mpcrt_pkg::ST_DONE)
			out_data_q <= err_q ? 64'd0 : 64'(r_q);
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = err_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mpcrt_pkg::ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_done_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpcrt_pkg::ST_DONE) |=> m_axis_tvalid) else $error("result lost");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0)) else $error("bad error result");
endmodule
`default_nettype wire

@@ hw/rtl/mpcrt_modunit.sv @@
// Shared modular unit: one bit per cycle, either b mod m (restoring shift-subtract)
// or a*b mod m (double-and-add over b). Depends on mpcrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpcrt_modunit #(
	parameter int W = mpcrt_pkg::WORD_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mpcrt_pkg::unit_ctl_t   ctl,
	input  wire logic [W-1:0]           a,
	input  wire logic [W-1:0]           b,
	input  wire logic [W-1:0]           m,
	output logic                        done,
	output logic [W-1:0]                result
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] acc_q, a_q, b_q, m_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, red_q, done_q;
	logic [W:0] sum_acc, dbl_a, shifted;
	logic [W-1:0] acc_add, a_dbl, rem_next;

	always_comb begin
		sum_acc = {1'b0, acc_q} + {1'b0, a_q};
		acc_add = (sum_acc >= {1'b0, m_q}) ? W'(sum_acc - {1'b0, m_q}) : sum_acc[W-1:0];
		dbl_a = {a_q, 1'b0};
		a_dbl = (dbl_a >= {1'b0, m_q}) ? W'(dbl_a - {1'b0, m_q}) : dbl_a[W-1:0];
		// Remainder step: shift in the next bit of the dividend, taken MSB first.
		shifted = {acc_q, b_q[W-1]};
		rem_next = (shifted >= {1'b0, m_q}) ? W'(shifted - {1'b0, m_q}) : shifted[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			red_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				red_q <= ctl.reduce;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			a_q <= a;
			b_q <= b;
			m_q <= m;
		end else if (busy_q) begin
			if (red_q) begin
				acc_q <= rem_next;
				b_q <= {b_q[W-2:0], 1'b0};
			end else begin
				if (b_q[0])
					acc_q <= acc_add;
				a_q <= a_dbl;
				b_q <= {1'b0, b_q[W-1:1]};
			end
		end
	end

	assign done = done_q;
	assign result = acc_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without work");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !ctl.start) else $error("start while busy");
	a_acc_below_m: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (acc_q < m_q)) else $error("result not reduced");
endmodule
`default_nettype wire
